// File: sv/mcg_pkg.sv
// Shared types, constants and helper functions for the month calendar grid.
// Used by mcg_ctrl, mcg_datapath and month_calendar_grid_core; no dependencies.
`default_nettype none

package mcg_pkg;

	// Calendar constants
	localparam logic [11:0] BASE_YEAR = 12'd1990;
	localparam int BASE_YM1_INT = 1989;
	localparam int LEAPS_BEFORE_INT = BASE_YM1_INT / 4 - BASE_YM1_INT / 100 + BASE_YM1_INT / 400;
	localparam logic [10:0] LEAPS_BEFORE_BASE = 11'(LEAPS_BEFORE_INT);
	localparam logic [12:0] BASE_YM1 = 13'(BASE_YM1_INT);
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

	// Reciprocal of 100: floor(y * 5243 / 2^19) == floor(y / 100) for 12-bit y
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [11:0] HUNDRED = 12'd100;

	// Grid geometry
	localparam logic [2:0] LAST_COL = 3'd6;
	localparam logic [5:0] LAST_CELL_IDX = 6'd41;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture year and month
		logic mul;      // multiply by reciprocal of 100
		logic leap;     // leap flag and leap count
		logic sum;      // day count and month length
		logic start;    // weekday reduction, clear cell counters
		logic adv;      // step to next cell
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;     // current cell is the final one
	} stat_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1: d = 9'd0;
			4'd2: d = 9'd31;
			4'd3: d = 9'd59;
			4'd4: d = 9'd90;
			4'd5: d = 9'd120;
			4'd6: d = 9'd151;
			4'd7: d = 9'd181;
			4'd8: d = 9'd212;
			4'd9: d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Remainder by 7: fold octal digits (8 == 1 mod 7), then one correction
	function automatic logic [2:0] mod7(input logic [12:0] v);
		logic [5:0] s;
		logic [3:0] t;
		s = {3'd0, v[2:0]} + {3'd0, v[5:3]} + {3'd0, v[8:6]} + {3'd0, v[11:9]}
			+ {5'd0, v[12]};
		t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/month_calendar_grid_core.sv
// Top level of the month calendar grid: controller plus datapath.
// Depends on mcg_pkg, mcg_ctrl and mcg_datapath.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | year_number, month_number
//  out     | output    | out_valid / out_ready| day_number, grid_row, grid_column, last_cell
//
// An item passes through the accept cycle, four setup steps (reciprocal multiply,
// leap step, day-count sum, mod-7 fold) and 42 cells at one per cycle while the output
// does not stall; in_ready rises in the cycle after the final cell is taken.
// Output stalls hold the current cell and lengthen the item for as long as they last.
// Reset (arst_n low) returns the controller to idle with in_ready high.
`default_nettype none

module month_calendar_grid_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] year_number,
	input  wire logic [3:0]  month_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       day_number,
	output logic [2:0]       grid_row,
	output logic [2:0]       grid_column,
	output logic             last_cell
);

	mcg_pkg::cmd_t  cmd;
	mcg_pkg::stat_t stat;

	mcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.year_number  (year_number),
		.month_number (month_number),
		.stat         (stat),
		.day_number   (day_number),
		.grid_row     (grid_row),
		.grid_column  (grid_column),
		.last_cell    (last_cell)
	);

	// Never take a new item while cells are still being shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid both high");

	// Final cell sits at the bottom right of the grid
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_cell) |-> (grid_row == 3'd5 && grid_column == 3'd6))
		else $error("last cell not at row 5 column 6");

	// Days run consecutively until the grid goes blank
	a_day_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_cell && day_number != 5'd0)
		|=> (day_number == 5'd0 || day_number == $past(day_number) + 5'd1))
		else $error("day numbers not consecutive");

	// Delivering the final cell frees the input side
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_cell) |=> (in_ready && !out_valid))
		else $error("block not idle after final cell");

endmodule

`default_nettype wire

// File: sv/mcg_ctrl.sv
// Controller for the month calendar grid: sequences the setup steps and cell output.
// Depends on mcg_pkg (cmd_t, stat_t).
`default_nettype none

module mcg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire mcg_pkg::stat_t stat,
	output mcg_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_LEAP,
		S_SUM,
		S_START,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_MUL;
						in_ready_q <= 1'b0;
					end
				end
				S_MUL: state_q <= S_LEAP;
				S_LEAP: state_q <= S_SUM;
				S_SUM: state_q <= S_START;
				S_START: begin
					state_q     <= S_EMIT;
					out_valid_q <= 1'b1;
				end
				S_EMIT: begin
					if (out_ready && stat.last) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
					in_ready_q  <= 1'b1;
				end
			endcase
		end
	end

	// Decode commands
	always_comb begin
		cmd       = '0;
		cmd.load  = in_valid && in_ready_q;
		cmd.mul   = (state_q == S_MUL);
		cmd.leap  = (state_q == S_LEAP);
		cmd.sum   = (state_q == S_SUM);
		cmd.start = (state_q == S_START);
		cmd.adv   = (state_q == S_EMIT) && out_valid_q && out_ready && !stat.last;
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/mcg_datapath.sv
// Datapath for the month calendar grid: weekday of the first day, month length
// and the cell counters. Depends on mcg_pkg.
`default_nettype none

module mcg_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mcg_pkg::cmd_t cmd,
	input  wire logic [11:0]   year_number,
	input  wire logic [3:0]    month_number,
	output mcg_pkg::stat_t     stat,
	output logic [4:0]         day_number,
	output logic [2:0]         grid_row,
	output logic [2:0]         grid_column,
	output logic               last_cell
);

	logic [11:0] ym1_q;
	logic [3:0]  mon_q;
	logic        mvalid_q;
	logic [24:0] prod_q;
	logic        leap_q;
	logic [9:0]  lcnt_q;
	logic [12:0] sum_q;
	logic [4:0]  mlen_q;
	logic [2:0]  start_q;
	logic [5:0]  k_q;
	logic [2:0]  row_q;
	logic [2:0]  col_q;

	logic [11:0] year_clamp;
	logic [5:0]  q100;
	logic [11:0] q_times;
	logic [6:0]  rem100;
	logic        leap_next;
	logic [10:0] lcnt_wide;
	logic [12:0] sum_next;
	logic [4:0]  mlen_next;
	logic [5:0]  kp1;
	logic [5:0]  day_off;
	logic        feb_leap;

	// Year and leap arithmetic
	always_comb begin
		year_clamp = (year_number < mcg_pkg::BASE_YEAR) ? mcg_pkg::BASE_YEAR : year_number;
		q100       = prod_q[24:19];
		q_times    = {6'd0, q100} * mcg_pkg::HUNDRED;
		rem100     = 7'(ym1_q - q_times);
		// year is leap: year-1 ends in 3 mod 4, and not a century unless mod 400
		leap_next  = (ym1_q[1:0] == 2'b11) && ((rem100 != 7'd99) || (q100[1:0] == 2'b11));
		lcnt_wide  = {1'b0, ym1_q[11:2]} - {5'd0, q100} + {7'd0, q100[5:2]}
			- mcg_pkg::LEAPS_BEFORE_BASE;
		sum_next   = ({1'b0, ym1_q} - mcg_pkg::BASE_YM1) + {3'd0, lcnt_q}
			+ {4'd0, mcg_pkg::days_before(mon_q)}
			+ {12'd0, leap_q && (mon_q > mcg_pkg::MONTH_FEB)} + 13'd1;
		feb_leap   = (mon_q == mcg_pkg::MONTH_FEB) && leap_q;
		if (!mvalid_q) begin
			mlen_next = 5'd0;
		end else if (feb_leap) begin
			mlen_next = mcg_pkg::FEB_LEAP_LEN;
		end else begin
			mlen_next = mcg_pkg::month_len(mon_q);
		end
	end

	// Capture and setup registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ym1_q    <= year_clamp - 12'd1;
			mon_q    <= month_number;
			mvalid_q <= (month_number >= mcg_pkg::MONTH_JAN)
				&& (month_number <= mcg_pkg::MONTH_DEC);
		end
		if (cmd.mul) begin
			prod_q <= {13'd0, ym1_q} * {12'd0, mcg_pkg::RECIP_100};
		end
		if (cmd.leap) begin
			leap_q <= leap_next;
			lcnt_q <= lcnt_wide[9:0];
		end
		if (cmd.sum) begin
			sum_q  <= sum_next;
			mlen_q <= mlen_next;
		end
		if (cmd.start) begin
			start_q <= mcg_pkg::mod7(sum_q);
		end
	end

	// Cell counters: clear on start, advance per accepted cell other than the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.start) begin
			k_q   <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.adv) begin
			k_q <= k_q + 6'd1;
			if (col_q == mcg_pkg::LAST_COL) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	// Day shown in the current cell
	always_comb begin
		kp1     = k_q + 6'd1;
		day_off = kp1 - {3'd0, start_q};
		if ((kp1 > {3'd0, start_q}) && (day_off <= {1'b0, mlen_q})) begin
			day_number = day_off[4:0];
		end else begin
			day_number = 5'd0;
		end
	end

	assign grid_row    = row_q;
	assign grid_column = col_q;
	assign last_cell   = (k_q == mcg_pkg::LAST_CELL_IDX);
	assign stat.last   = last_cell;

endmodule

`default_nettype wire

// File: dv/month_calendar_grid_checker.sv
// Checker for month_calendar_grid_core: watches both channels, predicts every grid cell.
// Stand-alone module with no package dependency; instantiated by month_calendar_grid_core_test.
module month_calendar_grid_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [11:0] year_number,
	input  logic [3:0]  month_number,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  day_number,
	input  logic [2:0]  grid_row,
	input  logic [2:0]  grid_column,
	input  logic        last_cell,
	output int          fail_count,
	output int          cells_pending,
	output int          cells_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned EPOCH_YEAR = 1990;
	localparam int unsigned WEEK_DAYS = 7;
	localparam int unsigned GRID_CELLS = 42;

	typedef struct packed {
		logic [4:0] day;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} grid_cell_t;

	grid_cell_t cells_due[$];

	function automatic int unsigned days_in_month(int unsigned mon, bit leap);
		case (mon)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// Lay out one month and queue its 42 cells in row-major order
	function automatic void queue_month_grid(logic [11:0] yr_in, logic [3:0] mon_in);
		int unsigned yr;
		int unsigned mon;
		int unsigned prev;
		int unsigned epoch_prev;
		int unsigned day_count;
		int unsigned first_wd;
		int unsigned mlen;
		int unsigned d;
		bit          leap;
		bit          real_month;
		grid_cell_t  due_cell;
		yr = yr_in;
		mon = mon_in;
		first_wd = 0;
		mlen = 0;
		// clamp early years to the epoch
		if (yr < EPOCH_YEAR) begin
			yr = EPOCH_YEAR;
		end
		real_month = (mon >= 1) && (mon <= 12);
		if (real_month) begin
			leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
			prev = yr - 1;
			epoch_prev = EPOCH_YEAR - 1;
			day_count = 365 * (yr - EPOCH_YEAR)
				+ (prev / 4 - prev / 100 + prev / 400)
				- (epoch_prev / 4 - epoch_prev / 100 + epoch_prev / 400);
			for (int unsigned m = 1; m < mon; m++) begin
				day_count += days_in_month(m, leap);
			end
			first_wd = (day_count + 1) % WEEK_DAYS;
			mlen = days_in_month(mon, leap);
		end
		for (int unsigned k = 0; k < GRID_CELLS; k++) begin
			d = 0;
			if (real_month && (k + 1 > first_wd) && (k + 1 - first_wd <= mlen)) begin
				d = k + 1 - first_wd;
			end
			due_cell.day = d[4:0];
			due_cell.row = 3'(k / WEEK_DAYS);
			due_cell.col = 3'(k % WEEK_DAYS);
			due_cell.last = (k == GRID_CELLS - 1);
			cells_due.push_back(due_cell);
		end
	endfunction

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Predict on each accepted month, compare each accepted cell with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		grid_cell_t want;
		if (!arst_n) begin
			cells_due.delete();
			fail_count = 0;
			cells_pending = 0;
			cells_checked = 0;
		end else begin
			if (in_valid && in_ready) begin
				queue_month_grid(year_number, month_number);
			end
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					$error("unexpected cell: day %0d row %0d column %0d last %0d",
						day_number, grid_row, grid_column, last_cell);
					fail_count++;
				end else begin
					want = cells_due.pop_front();
					compare_field("day_number", want.day, day_number);
					compare_field("grid_row", want.row, grid_row);
					compare_field("grid_column", want.col, grid_column);
					compare_field("last_cell", want.last, last_cell);
					cells_checked++;
				end
			end
			cells_pending = cells_due.size();
		end
	end

endmodule

// File: dv/month_calendar_grid_core_test.sv
// Testbench top for month_calendar_grid_core: clock, reset, month stimulus and verdict.
// Depends on month_calendar_grid_core (RTL) and month_calendar_grid_checker.
module month_calendar_grid_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE} pace_t;

	localparam int RANDOM_MONTHS = 470;
	localparam int BACKLOG_CYCLES = 500;
	localparam int DRAIN_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] year_number;
	logic [3:0]  month_number;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  day_number;
	logic [2:0]  grid_row;
	logic [2:0]  grid_column;
	logic        last_cell;

	int    fail_count;
	int    cells_pending;
	int    cells_checked;
	int    months_sent;
	int    src_idle_pct;
	int    sink_idle_pct;
	pace_t pace;
	bit    backlog_done;

	month_calendar_grid_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.year_number (year_number),
		.month_number(month_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.day_number  (day_number),
		.grid_row    (grid_row),
		.grid_column (grid_column),
		.last_cell   (last_cell)
	);

	month_calendar_grid_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.year_number  (year_number),
		.month_number (month_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.day_number   (day_number),
		.grid_row     (grid_row),
		.grid_column  (grid_column),
		.last_cell    (last_cell),
		.fail_count   (fail_count),
		.cells_pending(cells_pending),
		.cells_checked(cells_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run well beyond the slowest legal pacing
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Map the pacing phase to idle percentages
	always_comb begin
		case (pace)
			PACE_SLOW_SINK: begin
				src_idle_pct = 34;
				sink_idle_pct = 73;
			end
			PACE_SLOW_SOURCE: begin
				src_idle_pct = 73;
				sink_idle_pct = 34;
			end
			default: begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
		endcase
	end

	// Drive out_ready; on entering the free phase, hold off once so the block backs up
	initial begin
		out_ready = 1'b0;
		backlog_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pace == PACE_FREE && !backlog_done) begin
				backlog_done = 1'b1;
				out_ready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// Offer one month, idling first at the current rate; entered and left at a falling edge
	task automatic send_month(logic [11:0] yr, logic [3:0] mon);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		year_number <= yr;
		month_number <= mon;
		do @(posedge clk); while (!in_ready);
		months_sent++;
		@(negedge clk);
	endtask

	initial begin
		logic [11:0] yr;
		logic [3:0]  mon;
		int          pick;
		int          directed;
		in_valid = 1'b0;
		year_number = '0;
		month_number = '0;
		months_sent = 0;
		pace = PACE_SLOW_SINK;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: epoch, clamping, leap rules, bad months, field extremes
		send_month(12'd1990, 4'd1);
		send_month(12'd4095, 4'd15);
		send_month(12'd0, 4'd0);
		send_month(12'd1989, 4'd2);
		send_month(12'd2000, 4'd2);
		send_month(12'd2100, 4'd2);
		send_month(12'd2024, 4'd2);
		send_month(12'd2024, 4'd3);
		send_month(12'd2023, 4'd2);
		send_month(12'd4095, 4'd12);
		send_month(12'd2025, 4'd13);
		for (int m = 1; m <= 12; m++) begin
			send_month(12'd2026, 4'(m));
		end
		directed = months_sent;

		// Random: mostly real months, some century years, some clamped or bad input
		for (int i = 0; i < RANDOM_MONTHS; i++) begin
			if (i == RANDOM_MONTHS / 3) begin
				pace = PACE_SLOW_SOURCE;
			end else if (i == 2 * RANDOM_MONTHS / 3) begin
				pace = PACE_FREE;
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				yr = 12'($urandom_range(1990, 4095));
				mon = 4'($urandom_range(1, 12));
			end else if (pick < 90) begin
				yr = 12'(100 * $urandom_range(20, 40));
				mon = 4'($urandom_range(1, 12));
			end else begin
				yr = 12'($urandom);
				mon = 4'($urandom);
			end
			send_month(yr, mon);
		end
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray cell
		wait (cells_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d months (%0d directed) under three pacing phases and one long backlog;",
			months_sent, directed);
		$display("checked %0d grid cells, %0d mismatches.", cells_checked, fail_count);
		if (fail_count == 0 && cells_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
